// ===== design/bis_pkg.sv =====
// Shared constants for the bounded integer set table.
package bis_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int VALUE_W  = 32;
  localparam int ACTION_W = 2;
  localparam int CAP_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int SIZE_W   = 5;

  localparam logic [ACTION_W-1:0] ACT_MEMBER = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

endpackage

// ===== design/bis_cell.sv =====
// One entry cell of the set table: holds a word, matches the key, extends the result chain.
module bis_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic [bis_pkg::VALUE_W-1:0]   key,
  input  logic                          occupied,
  input  logic                          is_last,
  input  logic                          we,
  input  logic [bis_pkg::VALUE_W-1:0]   wdata,
  input  logic                          hit_i,
  input  logic [IW-1:0]                 hit_idx_i,
  input  logic [bis_pkg::VALUE_W-1:0]   last_data_i,
  output logic                          hit_o,
  output logic [IW-1:0]                 hit_idx_o,
  output logic [bis_pkg::VALUE_W-1:0]   last_data_o
);
  import bis_pkg::*;

  logic [VALUE_W-1:0] entry_r;
  logic               match;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_r <= wdata;
    end
  end

  // Entries are distinct, so at most one cell matches and the chain can merge by OR.
  assign match       = occupied && (entry_r == key);
  assign hit_o       = hit_i | match;
  assign hit_idx_o   = hit_idx_i | (match ? IW'(IDX) : '0);
  assign last_data_o = last_data_i | (is_last ? entry_r : '0);

endmodule

// ===== design/bounded_integer_set_table.sv =====
// Top level of the bounded integer set table: control, count and the row of entry cells.
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_action, in_value
//   out_      output     out_valid / out_ready out_found, out_slot, out_changed, out_size
//   cfg_      input      cfg_we                cfg_wdata (capacity)
//
// An item is captured in ST_IDLE, and in ST_EXEC every cell compares the key
// and the store and count update. The result sits in an output register; the next item
// is taken while it waits. If that register is still full when a result is ready, the
// update holds until the result is transferred. Reset clears the count and restores the
// capacity to 16; entry words are never read before they are written.
module bounded_integer_set_table #(
  parameter int DEPTH = bis_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bis_pkg::ACTION_W-1:0]        in_action,
  input  logic signed [bis_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [bis_pkg::SLOT_W-1:0]          out_slot,
  output logic                                out_changed,
  output logic [bis_pkg::SIZE_W-1:0]          out_size,
  input  logic                                cfg_we,
  input  logic [bis_pkg::CAP_W-1:0]           cfg_wdata
);
  import bis_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = ((CW > CAP_W) ? CW : CAP_W) + 1;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  state_t              state_r;
  logic [ACTION_W-1:0] action_r;
  logic [VALUE_W-1:0]  key_r;
  logic [CW-1:0]       count_r;
  logic [CAP_W-1:0]    capacity_r;
  logic                out_valid_r;
  logic                out_found_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_changed_r;
  logic [SIZE_W-1:0]   out_size_r;

  logic               hit_chain [DEPTH+1];
  logic [IW-1:0]      idx_chain [DEPTH+1];
  logic [VALUE_W-1:0] last_chain[DEPTH+1];

  logic               hit;
  logic [IW-1:0]      hit_idx;
  logic [VALUE_W-1:0] last_data;
  logic               out_free;
  logic               commit;
  logic               room;
  logic               do_add;
  logic               do_rm;
  logic [CW-1:0]      count_nxt;
  logic [VALUE_W-1:0] wdata;

  assign hit_chain[0]  = 1'b0;
  assign idx_chain[0]  = '0;
  assign last_chain[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic cell_we;
    assign cell_we = (do_add && (count_r == CW'(i))) || (do_rm && (hit_idx == IW'(i)));

    bis_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .key         (key_r),
      .occupied    (count_r > CW'(i)),
      .is_last     (count_r == CW'(i + 1)),
      .we          (cell_we),
      .wdata       (wdata),
      .hit_i       (hit_chain[i]),
      .hit_idx_i   (idx_chain[i]),
      .last_data_i (last_chain[i]),
      .hit_o       (hit_chain[i+1]),
      .hit_idx_o   (idx_chain[i+1]),
      .last_data_o (last_chain[i+1])
    );
  end

  assign hit       = hit_chain[DEPTH];
  assign hit_idx   = idx_chain[DEPTH];
  assign last_data = last_chain[DEPTH];

  // The effective capacity saturates at the number of cells.
  assign room = (WW'(count_r) < WW'(capacity_r)) && (WW'(count_r) < WW'(DEPTH));

  assign out_free = !out_valid_r || out_ready;
  assign commit   = (state_r == ST_EXEC) && out_free;
  assign do_add   = commit && (action_r == ACT_ADD) && !hit && room;
  assign do_rm    = commit && (action_r == ACT_REMOVE) && hit;
  assign wdata    = do_add ? key_r : last_data;

  always_comb begin
    count_nxt = count_r;
    if (do_add) begin
      count_nxt = count_r + CW'(1);
    end else if (do_rm) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      // A new result in the same cycle keeps the output register full.
      if (out_valid_r && out_ready && !commit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            action_r <= in_action;
            key_r    <= in_value;
            state_r  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            count_r       <= count_nxt;
            out_valid_r   <= 1'b1;
            out_found_r   <= hit;
            out_changed_r <= do_add || do_rm;
            out_size_r    <= SIZE_W'(count_nxt);
            if (do_add) begin
              out_slot_r <= SLOT_W'(count_r);
            end else if (hit) begin
              out_slot_r <= SLOT_W'(hit_idx);
            end else begin
              out_slot_r <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready    = (state_r == ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_found   = out_found_r;
  assign out_slot    = out_slot_r;
  assign out_changed = out_changed_r;
  assign out_size    = out_size_r;

endmodule
